/* rtl/key_debounce_long_press_assert.svh */
// Assertion macros shared by the key debounce checker.
// Depends on clk_i and rst_ni being visible where the macros are used.
`ifndef KEY_DEBOUNCE_LONG_PRESS_ASSERT_SVH
`define KEY_DEBOUNCE_LONG_PRESS_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define KDLP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("key debounce assertion failed");

// Next-cycle implication, disabled during reset
`define KDLP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("key debounce assertion failed");

`endif

/* rtl/kdlp_pkg.sv */
// Shared types and constants for the key debounce block.
// No dependencies; imported by the lane, merge and top modules.
package kdlp_pkg;

  localparam int unsigned CfgW = 8;
  localparam logic [7:0]  LevelStep = 8'h3F;

  // Register indexes
  localparam logic [1:0] RegRise = 2'd0;
  localparam logic [1:0] RegFall = 2'd1;
  localparam logic [1:0] RegLong = 2'd2;

  // Register reset values
  localparam logic [CfgW-1:0] RiseReset = 8'd200;
  localparam logic [CfgW-1:0] FallReset = 8'd55;
  localparam logic [CfgW-1:0] LongReset = 8'd25;

  typedef struct packed {
    logic [CfgW-1:0] rise_thr;
    logic [CfgW-1:0] fall_thr;
    logic [CfgW-1:0] long_ticks;
  } cfg_t;

  typedef struct packed {
    logic deb;
    logic shrt;
    logic lng;
  } lane_res_t;

endpackage

/* rtl/kdlp_lane.sv */
// One key lane: leaky level filter, Schmitt flag and hold counter.
// Depends on kdlp_pkg for the configuration and result types.
module kdlp_lane (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                raw_i,
  input  kdlp_pkg::cfg_t      cfg_i,
  output kdlp_pkg::lane_res_t res_o
);
  import kdlp_pkg::*;

  logic [7:0] level_q, level_d;
  logic       flag_q, flag_d;
  logic [7:0] cnt_q, cnt_d;
  logic       rep_q, rep_d;
  logic [7:0] decayed;
  logic       flag_set;

  // Update filter, flag and counter for this tick
  always_comb begin
    decayed  = level_q - (level_q >> 2);
    level_d  = raw_i ? decayed + LevelStep : decayed;
    flag_set = (level_d > cfg_i.rise_thr) ? 1'b1 : flag_q;
    flag_d   = (level_d < cfg_i.fall_thr) ? 1'b0 : flag_set;
    cnt_d    = cnt_q;
    rep_d    = rep_q;
    res_o.deb  = flag_d;
    res_o.shrt = 1'b0;
    res_o.lng  = 1'b0;
    if (flag_d) begin
      if (cnt_q < cfg_i.long_ticks) begin
        cnt_d = cnt_q + 8'd1;
      end
      if ((cnt_d >= cfg_i.long_ticks) && !rep_q) begin
        rep_d     = 1'b1;
        res_o.lng = 1'b1;
      end
    end else begin
      res_o.shrt = (cnt_q != 8'd0) && (cnt_q < cfg_i.long_ticks);
      cnt_d      = 8'd0;
      rep_d      = 1'b0;
    end
  end

  // Advance lane state on each accepted tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= 8'd0;
      flag_q  <= 1'b0;
      cnt_q   <= 8'd0;
      rep_q   <= 1'b0;
    end else if (en_i) begin
      level_q <= level_d;
      flag_q  <= flag_d;
      cnt_q   <= cnt_d;
      rep_q   <= rep_d;
    end
  end

endmodule

/* rtl/kdlp_merge.sv */
// Merge stage: packs lane results into key vectors and buffers two results.
// Depends on kdlp_pkg for the lane result type.
module kdlp_merge #(
  parameter int unsigned KEYS = 2
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push_i,
  input  kdlp_pkg::lane_res_t [KEYS-1:0]  lanes_i,
  output logic                            full_o,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [KEYS-1:0]                 debounced_keys_o,
  output logic [KEYS-1:0]                 short_press_o,
  output logic [KEYS-1:0]                 long_press_o
);
  import kdlp_pkg::*;

  localparam int unsigned EntW = 3 * KEYS;

  logic [EntW-1:0] buf_q [2];
  logic [EntW-1:0] packed_res;
  logic            wr_ptr_q, rd_ptr_q;
  logic [1:0]      count_q;
  logic            pop;
  logic [KEYS-1:0] deb_v, shrt_v, lng_v;

  // Combine lane flags into per-field vectors
  always_comb begin
    for (int k = 0; k < KEYS; k++) begin
      deb_v[k]  = lanes_i[k].deb;
      shrt_v[k] = lanes_i[k].shrt;
      lng_v[k]  = lanes_i[k].lng;
    end
    packed_res = {lng_v, shrt_v, deb_v};
  end

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (count_q != 2'd0);
  assign full_o      = (count_q == 2'd2);

  // Track fill level and pointers of the result buffer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push_i && !pop) begin
        count_q <= count_q + 2'd1;
      end else if (pop && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  // Store merged result on each transfer in
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_ptr_q] <= packed_res;
    end
  end

  assign debounced_keys_o = buf_q[rd_ptr_q][KEYS-1:0];
  assign short_press_o    = buf_q[rd_ptr_q][2*KEYS-1:KEYS];
  assign long_press_o     = buf_q[rd_ptr_q][3*KEYS-1:2*KEYS];

endmodule

/* rtl/key_debounce_long_press.sv */
// A scan tick's result is registered into the result buffer on transfer in.
// One scan tick per cycle while the buffer is not full; lanes update together.
// A two-entry result buffer keeps input transfers going while a result waits.
// Reset (rst_ni low, async) clears all lane levels, flags, counters and the
// buffer, and loads thresholds 200, 55 and long-press ticks 25.
// Top level: APB registers, one lane per key, merge stage.
module key_debounce_long_press #(
  parameter int unsigned KEYS = 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [3:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [KEYS-1:0] raw_keys_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [KEYS-1:0] debounced_keys_o,
  output logic [KEYS-1:0] short_press_o,
  output logic [KEYS-1:0] long_press_o
);
  import kdlp_pkg::*;

  cfg_t                  cfg_q;
  logic [1:0]            reg_idx;
  logic                  cfg_wr;
  logic                  accept;
  logic                  full;
  lane_res_t [KEYS-1:0]  lane_res;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rise_thr   <= RiseReset;
      cfg_q.fall_thr   <= FallReset;
      cfg_q.long_ticks <= LongReset;
    end else if (cfg_wr) begin
      case (reg_idx)
        RegRise: cfg_q.rise_thr   <= pwdata[CfgW-1:0];
        RegFall: cfg_q.fall_thr   <= pwdata[CfgW-1:0];
        RegLong: cfg_q.long_ticks <= pwdata[CfgW-1:0];
        default: ;
      endcase
    end
  end

  // Read back configuration registers
  always_comb begin
    case (reg_idx)
      RegRise: prdata = {24'd0, cfg_q.rise_thr};
      RegFall: prdata = {24'd0, cfg_q.fall_thr};
      RegLong: prdata = {24'd0, cfg_q.long_ticks};
      default: prdata = 32'd0;
    endcase
  end

  assign in_ready_o = !full;
  assign accept     = in_valid_i && in_ready_o;

  // One lane per key
  for (genvar k = 0; k < KEYS; k++) begin : g_lane
    kdlp_lane u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (accept),
      .raw_i  (raw_keys_i[k]),
      .cfg_i  (cfg_q),
      .res_o  (lane_res[k])
    );
  end

  kdlp_merge #(.KEYS(KEYS)) u_merge (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push_i           (accept),
    .lanes_i          (lane_res),
    .full_o           (full),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .debounced_keys_o (debounced_keys_o),
    .short_press_o    (short_press_o),
    .long_press_o     (long_press_o)
  );

endmodule

/* rtl/kdlp_checker.sv */
// Port-level checker for key_debounce_long_press, bound to the top level.
// Depends on key_debounce_long_press_assert.svh for the assertion macros.
`include "key_debounce_long_press_assert.svh"

module kdlp_checker #(
  parameter int unsigned KEYS = 2
) (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            out_valid_o,
  input logic            out_ready_i,
  input logic [KEYS-1:0] debounced_keys_o,
  input logic [KEYS-1:0] short_press_o,
  input logic [KEYS-1:0] long_press_o
);

  // Hold a stalled result
  `KDLP_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable({debounced_keys_o, short_press_o, long_press_o}))

  // Drop no key into both press kinds at once
  `KDLP_ASSERT_NOW(a_press_excl, out_valid_o, (short_press_o & long_press_o) == '0)

  // Short press only on a released key
  `KDLP_ASSERT_NOW(a_short_released, out_valid_o, (short_press_o & debounced_keys_o) == '0)

  // Long press only on a held key
  `KDLP_ASSERT_NOW(a_long_held, out_valid_o, (long_press_o & ~debounced_keys_o) == '0)

endmodule

bind key_debounce_long_press kdlp_checker #(.KEYS(KEYS)) u_kdlp_checker (.*);
